>>> design/c2d_pkg.sv
`default_nettype none
package c2d_pkg;

  typedef enum logic [1:0] {
    CMD_IMG  = 2'd0,
    CMD_WGT  = 2'd1,
    CMD_BIAS = 2'd2,
    CMD_CONV = 2'd3
  } cmd_e;

  localparam int NUM_REGS = 8;
  localparam logic [2:0] REG_IMG_W  = 3'd0;
  localparam logic [2:0] REG_IMG_H  = 3'd1;
  localparam logic [2:0] REG_KER_W  = 3'd2;
  localparam logic [2:0] REG_KER_H  = 3'd3;
  localparam logic [2:0] REG_STEP_X = 3'd4;
  localparam logic [2:0] REG_STEP_Y = 3'd5;
  localparam logic [2:0] REG_BORD_X = 3'd6;
  localparam logic [2:0] REG_BORD_Y = 3'd7;

  localparam int CfgW = 6;
  localparam int ResW = 48;

  // Geometry shared between top and sequencer
  typedef struct packed {
    logic [8:0] w;
    logic [8:0] h;
    logic [4:0] kw;
    logic [4:0] kh;
    logic [3:0] sx;
    logic [3:0] sy;
    logic [2:0] px;
    logic [2:0] py;
  } geom_t;

  // Saturate a 32-bit signed value to 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    logic signed [15:0] r;
    if (v > 32'sd32767) r = 16'sh7fff;
    else if (v < -32'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/c2d_seq.sv
`default_nettype none
// Tap walker: steps (ky, kx, c) and emits one store address pair per cycle
module c2d_seq #(
  parameter int MAX_IMAGE_W  = 32,
  parameter int MAX_IMAGE_H  = 32,
  parameter int MAX_KERNEL_W = 8,
  parameter int MAX_KERNEL_H = 8,
  parameter int CHANNELS_IN  = 4,
  parameter int IAW = 12,
  parameter int WAW = 11,
  parameter int OCW = 3
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              start_i,
  input  c2d_pkg::geom_t   geom_i,
  input  wire [OCW-1:0]    oc_i,
  input  wire signed [10:0] bx_i,   // ox*sx - px
  input  wire signed [10:0] by_i,   // oy*sy - py
  output logic             busy_o,
  output logic             tap_vld_o,
  output logic             last_o,
  output logic [IAW-1:0]   img_addr_o,
  output logic [WAW-1:0]   wgt_addr_o
);
  localparam int CW = (CHANNELS_IN > 1) ? $clog2(CHANNELS_IN) : 1;

  logic        busy_q, busy_d;
  logic [4:0]  kx_q, kx_d, ky_q, ky_d;
  logic [CW-1:0] c_q, c_d;
  logic signed [11:0] ix, iy;
  logic        in_img, last_c, last_kx, last_ky;

  assign ix = 12'(bx_i) + 12'(kx_q);
  assign iy = 12'(by_i) + 12'(ky_q);
  assign in_img = (ix >= 0) && (ix < $signed({3'b0, geom_i.w})) &&
                  (iy >= 0) && (iy < $signed({3'b0, geom_i.h}));
  assign last_c  = (32'(c_q) == CHANNELS_IN - 1);
  assign last_kx = (kx_q == geom_i.kw - 5'd1);
  assign last_ky = (ky_q == geom_i.kh - 5'd1);

  // Advance counters
  always_comb begin
    busy_d = busy_q;
    kx_d = kx_q;
    ky_d = ky_q;
    c_d  = c_q;
    if (start_i) begin
      busy_d = 1'b1;
      kx_d = '0; ky_d = '0; c_d = '0;
    end else if (busy_q) begin
      if (!last_c) c_d = c_q + 1'b1;
      else begin
        c_d = '0;
        if (!last_kx) kx_d = kx_q + 5'd1;
        else begin
          kx_d = '0;
          if (!last_ky) ky_d = ky_q + 5'd1;
          else busy_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      kx_q <= '0; ky_q <= '0; c_q <= '0;
    end else begin
      busy_q <= busy_d;
      kx_q <= kx_d; ky_q <= ky_d; c_q <= c_d;
    end
  end

  assign busy_o    = busy_q;
  assign tap_vld_o = busy_q && in_img;
  assign last_o    = busy_q && last_c && last_kx && last_ky;

  // Fixed-pitch addresses
  always_comb begin
    img_addr_o = IAW'(((32'(c_q) * MAX_IMAGE_H + 32'(iy[8:0])) * MAX_IMAGE_W)
                      + 32'(ix[8:0]));
    wgt_addr_o = WAW'((((32'(oc_i) * CHANNELS_IN + 32'(c_q)) * MAX_KERNEL_H
                      + 32'(ky_q)) * MAX_KERNEL_W) + 32'(kx_q));
  end
endmodule
`default_nettype wire

>>> design/c2d_mac.sv
`default_nettype none
// Multiply-accumulate: product registered, then summed
module c2d_mac (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               clr_i,
  input  wire signed [31:0] bias_i,
  input  wire               vld_i,
  input  wire signed [15:0] a_i,
  input  wire signed [15:0] b_i,
  output logic signed [47:0] sat_o
);
  logic signed [31:0] prod_q;
  logic               pv_q;
  logic signed [55:0] acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pv_q <= 1'b0;
    else pv_q <= vld_i && !clr_i;
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    if (clr_i) acc_q <= 56'(bias_i);
    else if (pv_q) acc_q <= acc_q + 56'(prod_q);
  end

  // Saturate to 48 bits
  always_comb begin
    if (acc_q > 56'sh007fffffffffff) sat_o = 48'sh7fffffffffff;
    else if (acc_q < -56'sh00800000000000) sat_o = 48'sh800000000000;
    else sat_o = acc_q[47:0];
  end
endmodule
`default_nettype wire

>>> design/conv2d_forward.sv
`default_nettype none
// conv2d_forward: fixed-point multi-channel 2D convolution.
// Input channel in_valid_i/in_stall_o carries one beat per command: cmd_i
// selects image write, weight write, bias write or compute. Writes give no
// result. A compute beat walks kernel_height x kernel_width x CHANNELS_IN
// taps, one memory read and one multiply per cycle through the image and
// weight memories. An out-of-grid compute walks no taps and returns
// status 1 with a zero result. One compute is in flight at a time;
// in_stall_o is high while it runs, and for a compute beat while a result
// waits.
// Output channel out_valid_o/out_stall_i holds conv_result_o and status_o
// until taken; a stalled result blocks the next compute only.
// Configuration: cfg_we_i, cfg_idx_i, cfg_data_i write a register per edge;
// the user must write only while idle, which the block does not enforce.
// Reset clears registers to defaults and all control state;
// store contents stay undefined until written.
module conv2d_forward #(
  parameter int MAX_IMAGE_W  = 32,
  parameter int MAX_IMAGE_H  = 32,
  parameter int MAX_KERNEL_W = 8,
  parameter int MAX_KERNEL_H = 8,
  parameter int CHANNELS_IN  = 4,
  parameter int CHANNELS_OUT = 8
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  wire [1:0]         cmd_i,
  input  wire [11:0]        index_i,
  input  wire signed [31:0] value_i,
  input  wire [2:0]         out_channel_i,
  input  wire [5:0]         out_col_i,
  input  wire [5:0]         out_row_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output logic signed [47:0] conv_result_o,
  output logic              status_o,
  input  wire               cfg_we_i,
  input  wire [2:0]         cfg_idx_i,
  input  wire [5:0]         cfg_data_i
);
  localparam int IMG_D = CHANNELS_IN * MAX_IMAGE_H * MAX_IMAGE_W;
  localparam int WGT_D = CHANNELS_OUT * CHANNELS_IN * MAX_KERNEL_H * MAX_KERNEL_W;
  localparam int IAW = (IMG_D > 1) ? $clog2(IMG_D) : 1;
  localparam int WAW = (WGT_D > 1) ? $clog2(WGT_D) : 1;
  localparam int OCW = (CHANNELS_OUT > 1) ? $clog2(CHANNELS_OUT) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GRID = 3'd1;
  localparam logic [2:0] S_RUN  = 3'd2;
  localparam logic [2:0] S_DR1  = 3'd3;
  localparam logic [2:0] S_DR2  = 3'd4;
  localparam logic [2:0] S_DR3  = 3'd5;

  logic [5:0] r_q [c2d_pkg::NUM_REGS];
  logic [2:0] st_q, st_d;
  c2d_pkg::geom_t g;
  logic in_acc, out_acc;
  logic [2:0] oc_q; logic [5:0] ox_q, oy_q;
  logic signed [10:0] bx_q, by_q;
  logic signed [10:0] spanx, spany;
  logic outside;
  logic ov_q; logic signed [47:0] res_q; logic stat_q;
  logic start;
  logic busy, tap_vld, last;
  logic [IAW-1:0] ia; logic [WAW-1:0] wa;
  logic signed [15:0] img_mem [IMG_D];
  logic signed [15:0] wgt_mem [WGT_D];
  logic signed [31:0] bias_mem [CHANNELS_OUT];
  logic signed [15:0] img_rd_q, wgt_rd_q;
  logic               rd_vld_q;
  logic signed [31:0] bias_rd_q;
  logic signed [47:0] sat;
  logic [2:0] bias_sel;

  // Clamp registers to legal geometry
  function automatic logic [8:0] clampv(input logic [5:0] v, input int hi);
    logic [8:0] r;
    if (v == 6'd0) r = 9'd1;
    else if (32'(v) > hi) r = 9'(hi);
    else r = 9'(v);
    return r;
  endfunction

  always_comb begin
    g.w  = clampv(r_q[c2d_pkg::REG_IMG_W], MAX_IMAGE_W);
    g.h  = clampv(r_q[c2d_pkg::REG_IMG_H], MAX_IMAGE_H);
    g.kw = 5'(clampv({2'b0, r_q[c2d_pkg::REG_KER_W][3:0]}, MAX_KERNEL_W));
    g.kh = 5'(clampv({2'b0, r_q[c2d_pkg::REG_KER_H][3:0]}, MAX_KERNEL_H));
    g.sx = 4'(clampv({2'b0, r_q[c2d_pkg::REG_STEP_X][3:0]}, 15));
    g.sy = 4'(clampv({2'b0, r_q[c2d_pkg::REG_STEP_Y][3:0]}, 15));
    g.px = r_q[c2d_pkg::REG_BORD_X][2:0];
    g.py = r_q[c2d_pkg::REG_BORD_Y][2:0];
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q[c2d_pkg::REG_IMG_W]  <= 6'd32; r_q[c2d_pkg::REG_IMG_H]  <= 6'd32;
      r_q[c2d_pkg::REG_KER_W]  <= 6'd3;  r_q[c2d_pkg::REG_KER_H]  <= 6'd3;
      r_q[c2d_pkg::REG_STEP_X] <= 6'd1;  r_q[c2d_pkg::REG_STEP_Y] <= 6'd1;
      r_q[c2d_pkg::REG_BORD_X] <= 6'd0;  r_q[c2d_pkg::REG_BORD_Y] <= 6'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        c2d_pkg::REG_IMG_W, c2d_pkg::REG_IMG_H: r_q[cfg_idx_i] <= cfg_data_i;
        c2d_pkg::REG_BORD_X, c2d_pkg::REG_BORD_Y:
          r_q[cfg_idx_i] <= {3'b0, cfg_data_i[2:0]};
        default: r_q[cfg_idx_i] <= {2'b0, cfg_data_i[3:0]};
      endcase
    end
  end

  // Hold off while computing; a waiting result holds off computes only
  assign in_stall_o = (st_q != S_IDLE) || (ov_q && cmd_i == c2d_pkg::CMD_CONV);
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = ov_q && !out_stall_i;

  // Store writes and registered reads
  always_ff @(posedge clk_i) begin
    if (in_acc && cmd_i == c2d_pkg::CMD_IMG && 32'(index_i) < IMG_D)
      img_mem[IAW'(index_i)] <= c2d_pkg::sat16(value_i);
    if (in_acc && cmd_i == c2d_pkg::CMD_WGT && 32'(index_i) < WGT_D)
      wgt_mem[WAW'(index_i)] <= c2d_pkg::sat16(value_i);
    if (in_acc && cmd_i == c2d_pkg::CMD_BIAS && 32'(index_i) < CHANNELS_OUT)
      bias_mem[OCW'(index_i)] <= value_i;
    img_rd_q <= img_mem[ia];
    wgt_rd_q <= wgt_mem[wa];
    if (in_acc) bias_rd_q <= bias_mem[OCW'(bias_sel)];
  end

  assign bias_sel = out_channel_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rd_vld_q <= 1'b0;
    else rd_vld_q <= tap_vld;
  end

  // Latch compute coordinates
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      oc_q <= out_channel_i; ox_q <= out_col_i; oy_q <= out_row_i;
    end
    bx_q <= 11'(ox_q * g.sx) - 11'(g.px);
    by_q <= 11'(oy_q * g.sy) - 11'(g.py);
  end

  // Output grid bounds; division replaced by compare against ox*sx
  assign spanx = 11'(g.w) + 11'({g.px, 1'b0}) - 11'(g.kw);
  assign spany = 11'(g.h) + 11'({g.py, 1'b0}) - 11'(g.kh);
  assign outside = (32'(oc_q) >= CHANNELS_OUT) || spanx < 0 || spany < 0 ||
                   (12'(ox_q * g.sx) > 12'(spanx)) ||
                   (12'(oy_q * g.sy) > 12'(spany));

  assign start = (st_q == S_GRID) && !outside;

  c2d_seq #(
    .MAX_IMAGE_W(MAX_IMAGE_W), .MAX_IMAGE_H(MAX_IMAGE_H),
    .MAX_KERNEL_W(MAX_KERNEL_W), .MAX_KERNEL_H(MAX_KERNEL_H),
    .CHANNELS_IN(CHANNELS_IN),
    .IAW(IAW), .WAW(WAW), .OCW(OCW)
  ) u_seq (
    .clk_i, .rst_ni, .start_i(start), .geom_i(g), .oc_i(OCW'(oc_q)),
    .bx_i(bx_q), .by_i(by_q), .busy_o(busy), .tap_vld_o(tap_vld),
    .last_o(last), .img_addr_o(ia), .wgt_addr_o(wa)
  );

  c2d_mac u_mac (
    .clk_i, .rst_ni, .clr_i(start), .bias_i(bias_rd_q), .vld_i(rd_vld_q),
    .a_i(img_rd_q), .b_i(wgt_rd_q), .sat_o(sat)
  );

  // Control sequence
  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: if (in_acc && cmd_i == c2d_pkg::CMD_CONV) st_d = S_GRID;
      S_GRID: st_d = outside ? S_IDLE : S_RUN;
      S_RUN:  if (last) st_d = S_DR1;
      S_DR1:  st_d = S_DR2;
      S_DR2:  st_d = S_DR3;
      S_DR3:  st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (out_acc) ov_q <= 1'b0;
      if ((st_q == S_GRID && outside) || st_q == S_DR3) ov_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_GRID && outside) begin
      res_q <= '0; stat_q <= 1'b1;
    end else if (st_q == S_DR3) begin
      res_q <= sat; stat_q <= 1'b0;
    end
  end

  assign out_valid_o   = ov_q;
  assign conv_result_o = res_q;
  assign status_o      = stat_q;

  // Tap walker runs only in the compute state
  a_busy_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (st_q == S_RUN)) else $error("walker busy outside run");
  // A result is raised only from the end of a compute
  a_res_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> ($past(st_q) == S_GRID || $past(st_q) == S_DR3))
    else $error("result without compute");
  // Held result stays until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_stall_i) |=> (ov_q && $stable(res_q)))
    else $error("result dropped");
endmodule
`default_nettype wire
